// File: rtl/cartridge_bank_controller_macros.svh
// assertion macros for the cartridge bank controller
// used by the top level only, no dependencies
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define CBC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbc assertion failed");

// next-cycle implication
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbc assertion failed");

`endif

// File: rtl/cbc_pkg.sv
// types, constants and decode functions of the cartridge bank controller
// no dependencies
`default_nettype none

package cbc_pkg;

   localparam int RAM_BANK_BYTES = 8192;
   localparam int RAM_BANK_COUNT = 4;
   localparam int STORE_BYTES    = RAM_BANK_BYTES * RAM_BANK_COUNT;
   localparam int RAM_ADDR_W     = $clog2(STORE_BYTES);
   localparam int OFFSET_W       = 13;
   localparam int RAM_BANK_W     = 2;
   localparam int ROM_BANK_W     = 8;
   localparam int BYTE_W         = 8;
   localparam int RAM_IDX_W      = RAM_BANK_W + OFFSET_W + 1;
   localparam int CSR_INDEX_W    = 2;

   localparam logic [BYTE_W-1:0] IDLE_BYTE       = 8'hFF;
   localparam logic [BYTE_W-1:0] RAM_ENABLE_BITS = 8'h0A;

   typedef enum logic [2:0] {
      REQ_RAM_ENABLE = 3'd0,
      REQ_LOW_BANK   = 3'd1,
      REQ_HIGH_BANK  = 3'd2,
      REQ_MODE       = 3'd3,
      REQ_RAM_READ   = 3'd4,
      REQ_RAM_WRITE  = 3'd5
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CART_TYPE = 2'd0,
      CSR_ROM_SIZE  = 2'd1,
      CSR_RAM_SIZE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CTL_NONE,
      CTL_MBC1,
      CTL_MBC2,
      CTL_MBC3,
      CTL_MBC5
   } ctl_kind_type;

   typedef struct packed {
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic                  ram_on;
      logic                  ram_ok;
   } bank_status_type;

   function automatic ctl_kind_type cart_ctl_kind(input logic [7:0] code);
      ctl_kind_type k;
      unique case (code)
         8'h01, 8'h02, 8'h03:                      k = CTL_MBC1;
         8'h05, 8'h06:                             k = CTL_MBC2;
         8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        k = CTL_MBC3;
         8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: k = CTL_MBC5;
         default:                                  k = CTL_NONE;
      endcase
      return k;
   endfunction

   function automatic logic cart_ram_fitted(input logic [7:0] code);
      logic f;
      unique case (code)
         8'h03, 8'h0F, 8'h10, 8'h13, 8'h1B, 8'h1E: f = 1'b1;
         default:                                  f = 1'b0;
      endcase
      return f;
   endfunction

   function automatic logic [ROM_BANK_W-1:0] rom_bank_mask(input logic [3:0] code);
      logic [16:0] m;
      m = (17'd2 << code) - 17'd1;
      return m[ROM_BANK_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/cbc_channels.sv
// request and response channel interfaces of the cartridge bank controller
// depends on cbc_pkg
`default_nettype none

interface cbc_req_if import cbc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          kind;
   logic [OFFSET_W-1:0] ram_offset;
   logic [BYTE_W-1:0]   write_data;

   modport source (output valid, kind, ram_offset, write_data, input ready);
   modport sink   (input valid, kind, ram_offset, write_data, output ready);
endinterface

interface cbc_rsp_if import cbc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     read_data;
   logic [ROM_BANK_W-1:0] rom_bank;
   logic [RAM_BANK_W-1:0] ram_bank;
   logic                  ram_on;

   modport source (output valid, read_data, rom_bank, ram_bank, ram_on, input ready);
   modport sink   (input valid, read_data, rom_bank, ram_bank, ram_on, output ready);
endinterface

`default_nettype wire

// File: rtl/cbc_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/cbc_regs.sv
// configuration and bank control registers with next-value decode
// depends on cbc_pkg
`default_nettype none

module cbc_regs import cbc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_write_data,
   input  wire logic                   accept,
   input  wire logic [2:0]             kind,
   input  wire logic [BYTE_W-1:0]      write_data,
   output bank_status_type             status
);

   logic [7:0]            cart_type_ff;
   logic [3:0]            rom_size_ff;
   logic [7:0]            ram_size_ff;
   logic [ROM_BANK_W-1:0] rom_bank_ff, rom_bank_in;
   logic [RAM_BANK_W-1:0] ram_bank_ff, ram_bank_in;
   logic                  ram_on_ff, ram_on_in;
   logic                  adv_mode_ff, adv_mode_in;

   ctl_kind_type          ctl;
   logic [ROM_BANK_W-1:0] mask;
   logic [ROM_BANK_W-1:0] low_d;
   logic                  switchable;

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff <= '0;
         rom_size_ff  <= '0;
         ram_size_ff  <= '0;
         rom_bank_ff  <= ROM_BANK_W'(1);
         ram_bank_ff  <= '0;
         ram_on_ff    <= 1'b0;
         adv_mode_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_CART_TYPE: cart_type_ff <= csr_write_data;
               CSR_ROM_SIZE:  rom_size_ff  <= csr_write_data[3:0];
               CSR_RAM_SIZE:  ram_size_ff  <= csr_write_data;
               default: ;
            endcase
         end
         rom_bank_ff <= rom_bank_in;
         ram_bank_ff <= ram_bank_in;
         ram_on_ff   <= ram_on_in;
         adv_mode_ff <= adv_mode_in;
      end
   end

   always_comb begin
      ctl         = cart_ctl_kind(cart_type_ff);
      mask        = rom_bank_mask(rom_size_ff);
      low_d       = write_data & mask;
      switchable  = (ram_size_ff == 8'd3) || (ram_size_ff == 8'd4) || (ram_size_ff == 8'd5);
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_on_in   = ram_on_ff;
      adv_mode_in = adv_mode_ff;
      if (accept) begin
         unique case (kind)
            REQ_RAM_ENABLE: ram_on_in = |(write_data & RAM_ENABLE_BITS);
            REQ_LOW_BANK: begin
               unique case (ctl)
                  CTL_MBC1: rom_bank_in = {rom_bank_ff[7:5],
                     (low_d[4:0] == 5'd0) ? 5'd1 : low_d[4:0]};
                  CTL_MBC2: rom_bank_in = {rom_bank_ff[7:4],
                     (low_d[3:0] == 4'd0) ? 4'd1 : low_d[3:0]};
                  CTL_MBC3: rom_bank_in = {rom_bank_ff[7],
                     (low_d[6:0] == 7'd0) ? 7'd1 : low_d[6:0]};
                  CTL_MBC5: rom_bank_in = low_d;
                  default: ;
               endcase
            end
            REQ_HIGH_BANK: begin
               unique case (ctl)
                  CTL_MBC1: begin
                     if (!adv_mode_ff) begin
                        rom_bank_in = {1'b0, write_data[1:0], rom_bank_ff[4:0]} & mask;
                     end else if (switchable) begin
                        ram_bank_in = write_data[1:0];
                     end
                  end
                  CTL_MBC3: begin
                     if (switchable) begin
                        ram_bank_in = write_data[1:0];
                     end
                  end
                  default: ;
               endcase
            end
            REQ_MODE: adv_mode_in = write_data[0];
            default: ;
         endcase
      end
   end

   assign status.rom_bank = rom_bank_in;
   assign status.ram_bank = ram_bank_in;
   assign status.ram_on   = ram_on_in;
   assign status.ram_ok   = cart_ram_fitted(cart_type_ff) && ram_on_ff;

endmodule

`default_nettype wire

// File: rtl/cartridge_bank_controller.sv
// a request is registered in the a stage, then in the out stage that drives the response
// throughput: one request per cycle while responses are not stalled; the external ram read is the registered stage
// bank registers are updated at the request edge, ram data joins in the stage after
// reset clears bank state to rom bank one, ram bank zero, ram off, simple mode
// ram contents are not cleared by reset, configuration resets to zero
// depends on cbc_pkg, cbc_channels, cbc_regs, cbc_ram and the assertion macros
`default_nettype none
`include "cartridge_bank_controller_macros.svh"

module cartridge_bank_controller import cbc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_write_data,
   cbc_req_if.sink                     req_bus,
   cbc_rsp_if.source                   rsp_bus
);

   bank_status_type       status;
   logic                  accept;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [RAM_IDX_W-1:0]  ram_idx;
   logic [BYTE_W-1:0]     ram_rd_data;

   logic                  a_valid_ff;
   logic                  a_rd_sel_ff;
   logic [ROM_BANK_W-1:0] a_rom_bank_ff;
   logic [RAM_BANK_W-1:0] a_ram_bank_ff;
   logic                  a_ram_on_ff;
   logic                  a_adv;

   logic                  out_valid_ff;
   logic [BYTE_W-1:0]     out_read_data_ff;
   logic [ROM_BANK_W-1:0] out_rom_bank_ff;
   logic [RAM_BANK_W-1:0] out_ram_bank_ff;
   logic                  out_ram_on_ff;

   assign a_adv         = a_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !a_valid_ff || a_adv;
   assign accept        = req_bus.valid && req_bus.ready;

   cbc_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .kind           (req_bus.kind),
      .write_data     (req_bus.write_data),
      .status         (status)
   );

   // bank offset wraps over the whole store
   assign ram_idx = RAM_IDX_W'(status.ram_bank) * RAM_IDX_W'(RAM_BANK_BYTES)
                  + RAM_IDX_W'(req_bus.ram_offset);
   assign ram_wr_en = accept && status.ram_ok && (req_bus.kind == REQ_RAM_WRITE);
   assign ram_rd_en = accept && status.ram_ok && (req_bus.kind == REQ_RAM_READ);

   cbc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_idx[RAM_ADDR_W-1:0]),
      .wr_data (req_bus.write_data),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
         if (a_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_rd_sel_ff   <= ram_rd_en;
         a_rom_bank_ff <= status.rom_bank;
         a_ram_bank_ff <= status.ram_bank;
         a_ram_on_ff   <= status.ram_on;
      end
      if (a_adv) begin
         out_read_data_ff <= a_rd_sel_ff ? ram_rd_data : IDLE_BYTE;
         out_rom_bank_ff  <= a_rom_bank_ff;
         out_ram_bank_ff  <= a_ram_bank_ff;
         out_ram_on_ff    <= a_ram_on_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.read_data = out_read_data_ff;
   assign rsp_bus.rom_bank  = out_rom_bank_ff;
   assign rsp_bus.ram_bank  = out_ram_bank_ff;
   assign rsp_bus.ram_on    = out_ram_on_ff;

   `CBC_ASSERT_SAME(a_ram_rw_excl, clock, reset, ram_wr_en, !ram_rd_en)
   `CBC_ASSERT_NEXT(a_accept_fills, clock, reset, accept, a_valid_ff)
   `CBC_ASSERT_NEXT(a_rd_hold, clock, reset, a_valid_ff && a_rd_sel_ff && !a_adv,
      $stable(ram_rd_data))
   `CBC_ASSERT_NEXT(a_adv_fills_out, clock, reset, a_adv, out_valid_ff)

endmodule

`default_nettype wire

// File: test/cart_bank_check_pkg.sv
// tracks the bank state and external ram of the cartridge bank controller
// and checks every response against the next expected one; depends on cbc_pkg
package cart_bank_check_pkg;
   import cbc_pkg::*;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0]     read_data;
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      logic                  ram_on;
   } bank_reply_type;

   class bank_reply_tracker;
      logic [7:0]            cart_type;
      logic [3:0]            rom_size;
      logic [7:0]            ram_size;
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      bit                    ram_enabled;
      bit                    advanced_mode;
      logic [BYTE_W-1:0]     ram_image [STORE_BYTES];
      bit                    ram_known [STORE_BYTES];
      logic [OFFSET_W-1:0]   known_offsets [RAM_BANK_COUNT][$];
      bank_reply_type        expected_replies [$];
      int                    errors;

      function new();
         cart_type     = '0;
         rom_size      = '0;
         ram_size      = '0;
         rom_bank      = 8'd1;
         ram_bank      = '0;
         ram_enabled   = 1'b0;
         advanced_mode = 1'b0;
         errors        = 0;
      endfunction

      function void set_register(input csr_index_type idx, input logic [7:0] value);
         case (idx)
            CSR_CART_TYPE: cart_type = value;
            CSR_ROM_SIZE:  rom_size  = value[3:0];
            CSR_RAM_SIZE:  ram_size  = value;
            default: ;
         endcase
      endfunction

      function ctl_kind_type controller();
         case (cart_type)
            8'h01, 8'h02, 8'h03:                      return CTL_MBC1;
            8'h05, 8'h06:                             return CTL_MBC2;
            8'h0F, 8'h10, 8'h11, 8'h12, 8'h13:        return CTL_MBC3;
            8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E: return CTL_MBC5;
            default:                                  return CTL_NONE;
         endcase
      endfunction

      function bit ram_fitted();
         case (cart_type)
            8'h03, 8'h0F, 8'h10, 8'h13, 8'h1B, 8'h1E: return 1'b1;
            default:                                  return 1'b0;
         endcase
      endfunction

      function bit banks_switchable();
         return ram_size == 8'd3 || ram_size == 8'd4 || ram_size == 8'd5;
      endfunction

      function logic [7:0] rom_mask();
         return 8'(((32'd2 << rom_size) - 32'd1) & 32'hFF);
      endfunction

      function int addr_of(input logic [OFFSET_W-1:0] offset);
         return (int'(ram_bank) * RAM_BANK_BYTES + int'(offset)) % STORE_BYTES;
      endfunction

      function bit unwritten(input logic [OFFSET_W-1:0] offset);
         return ram_fitted() && ram_enabled && !ram_known[addr_of(offset)];
      endfunction

      function bit pick_known_offset(inout logic [OFFSET_W-1:0] offset);
         int b;
         b = int'(ram_bank);
         if (known_offsets[b].size() == 0)
            return 1'b0;
         offset = known_offsets[b][$urandom_range(0, known_offsets[b].size() - 1)];
         return 1'b1;
      endfunction

      function void write_low_bank(input logic [7:0] data);
         logic [7:0] d;
         d = data & rom_mask();
         case (controller())
            CTL_MBC1: begin
               d = d & 8'h1F;
               if (d == 8'h00) d = 8'h01;
               rom_bank = (rom_bank & 8'hE0) | d;
            end
            CTL_MBC2: begin
               d = d & 8'h0F;
               if (d == 8'h00) d = 8'h01;
               rom_bank = (rom_bank & 8'hF0) | d;
            end
            CTL_MBC3: begin
               d = d & 8'h7F;
               if (d == 8'h00) d = 8'h01;
               rom_bank = (rom_bank & 8'h80) | d;
            end
            CTL_MBC5: rom_bank = d;
            default: ;
         endcase
      endfunction

      function void write_high_bank(input logic [7:0] data);
         logic [1:0] d;
         d = data[1:0];
         case (controller())
            CTL_MBC1: begin
               if (!advanced_mode)
                  rom_bank = ({1'b0, d, 5'b0} | (rom_bank & 8'h1F)) & rom_mask();
               else if (banks_switchable())
                  ram_bank = d;
            end
            CTL_MBC3: begin
               if (banks_switchable()) ram_bank = d;
            end
            default: ;
         endcase
      endfunction

      function void note_request(input logic [2:0] kind, input logic [OFFSET_W-1:0] offset,
                                 input logic [BYTE_W-1:0] data);
         bank_reply_type r;
         bit ram_ok;
         int addr;
         ram_ok = ram_fitted() && ram_enabled;
         addr = addr_of(offset);
         r.read_data = IDLE_BYTE;
         case (kind)
            REQ_RAM_ENABLE: ram_enabled = (data & RAM_ENABLE_BITS) != '0;
            REQ_LOW_BANK:   write_low_bank(data);
            REQ_HIGH_BANK:  write_high_bank(data);
            REQ_MODE:       advanced_mode = data[0];
            REQ_RAM_READ: begin
               if (ram_ok) r.read_data = ram_image[addr];
            end
            REQ_RAM_WRITE: begin
               if (ram_ok) begin
                  ram_image[addr] = data;
                  if (!ram_known[addr]) begin
                     ram_known[addr] = 1'b1;
                     known_offsets[addr / RAM_BANK_BYTES].push_back(
                        OFFSET_W'(addr % RAM_BANK_BYTES));
                  end
               end
            end
            default: ;
         endcase
         r.rom_bank = rom_bank;
         r.ram_bank = ram_bank;
         r.ram_on   = ram_enabled;
         expected_replies.push_back(r);
      endfunction

      function void check_reply(input bank_reply_type got);
         bank_reply_type want;
         if (expected_replies.size() == 0) begin
            $error("unexpected response: read_data %h rom_bank %h ram_bank %h ram_on %b",
                   got.read_data, got.rom_bank, got.ram_bank, got.ram_on);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
            errors++;
         end
         if (got.rom_bank !== want.rom_bank) begin
            $error("rom_bank: expected %h, actual %h", want.rom_bank, got.rom_bank);
            errors++;
         end
         if (got.ram_bank !== want.ram_bank) begin
            $error("ram_bank: expected %h, actual %h", want.ram_bank, got.ram_bank);
            errors++;
         end
         if (got.ram_on !== want.ram_on) begin
            $error("ram_on: expected %b, actual %b", want.ram_on, got.ram_on);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: test/tb_cartridge_bank_controller.sv
// top-level testbench of the cartridge bank controller: directed and random requests
// under several configurations, with random stalls on both channels
// depends on cbc_pkg, cbc_channels, cart_bank_check_pkg and the rtl
module tb_cartridge_bank_controller import cbc_pkg::*, cart_bank_check_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 125;
   localparam logic [7:0] CART_CODES [PHASES] = '{
      8'h01, 8'h03, 8'h05, 8'h06, 8'h0F, 8'h10, 8'h11,
      8'h12, 8'h19, 8'h00, 8'hFF, 8'h1E, 8'h13, 8'h1B};
   localparam logic [7:0] RAM_SIZES [8] = '{
      8'd3, 8'd4, 8'd5, 8'd0, 8'd255, 8'd2, 8'd6, 8'd1};
   localparam int IDLE_LEVELS [3] = '{0, 5, 15};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_write_data;
   int                     idle_pct = 0;
   int                     quiet_cycles = 0;

   cbc_req_if req_bus ();
   cbc_rsp_if rsp_bus ();

   bank_reply_tracker tracker = new();

   cartridge_bank_controller uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_reply({rsp_bus.read_data, rsp_bus.rom_bank, rsp_bus.ram_bank,
                              rsp_bus.ram_on});
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [2:0] kind, input logic [OFFSET_W-1:0] offset,
                               input logic [BYTE_W-1:0] data);
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.ram_offset <= offset;
      req_bus.write_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(kind, offset, data);
      @(negedge clock);
   endtask

   task automatic pause_requests(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      tracker.set_register(idx, value);
      @(negedge clock);
   endtask

   task automatic load_config(input logic [7:0] cart, input logic [3:0] rom_size,
                              input logic [7:0] ram_size);
      write_csr(CSR_CART_TYPE, cart);
      write_csr(CSR_ROM_SIZE, {4'b0, rom_size});
      write_csr(CSR_RAM_SIZE, ram_size);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic [2:0]          kind;
      logic [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]   data;
      int                  pick;
      pick = $urandom_range(0, 99);
      data = BYTE_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0:       offset = OFFSET_W'($urandom_range(0, 15));
         1:       offset = OFFSET_W'({OFFSET_W{1'b1}} - $urandom_range(0, 15));
         default: offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
      endcase
      if (pick < 8) begin
         kind = REQ_RAM_ENABLE;
         if ($urandom_range(0, 9) < 7) data = RAM_ENABLE_BITS;
      end else if (pick < 20) begin
         kind = REQ_LOW_BANK;
      end else if (pick < 30) begin
         kind = REQ_HIGH_BANK;
      end else if (pick < 36) begin
         kind = REQ_MODE;
      end else if (pick < 62) begin
         kind = REQ_RAM_READ;
         if ($urandom_range(0, 9) < 7) void'(tracker.pick_known_offset(offset));
         if (tracker.unwritten(offset) && !tracker.pick_known_offset(offset))
            kind = REQ_RAM_WRITE;
      end else if (pick < 97) begin
         kind = REQ_RAM_WRITE;
      end else begin
         kind = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      end
      send_request(kind, offset, data);
   endtask

   initial begin : stimulus
      int phase;
      csr_write_en       = 1'b0;
      csr_index          = CSR_CART_TYPE;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.kind       = REQ_RAM_ENABLE;
      req_bus.ram_offset = '0;
      req_bus.write_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // mbc1 with ram, full rom mask, switchable ram banks
      load_config(8'h03, 4'd8, 8'd3);
      send_request(REQ_RAM_READ, '0, 8'h00);
      send_request(REQ_RAM_WRITE, '0, 8'h5A);
      send_request(REQ_RAM_ENABLE, '0, 8'hF5);
      send_request(REQ_RAM_ENABLE, '0, 8'h02);
      send_request(REQ_RAM_ENABLE, '0, 8'h08);
      send_request(REQ_RAM_ENABLE, '0, 8'h00);
      send_request(REQ_RAM_ENABLE, '0, 8'hFF);
      send_request(REQ_LOW_BANK, '0, 8'h00);
      send_request(REQ_LOW_BANK, '0, 8'hFF);
      send_request(REQ_HIGH_BANK, '0, 8'h03);
      send_request(REQ_LOW_BANK, '0, 8'h20);
      send_request(REQ_MODE, '0, 8'hFF);
      send_request(REQ_HIGH_BANK, '0, 8'hFE);
      send_request(REQ_RAM_WRITE, 13'h0000, 8'h00);
      send_request(REQ_RAM_WRITE, 13'h1FFF, 8'hFF);
      send_request(REQ_RAM_WRITE, 13'h1555, 8'hAA);
      send_request(REQ_RAM_WRITE, 13'h0AAA, 8'h55);
      send_request(REQ_RAM_READ, 13'h0000, 8'h00);
      send_request(REQ_RAM_READ, 13'h1FFF, 8'h00);
      send_request(REQ_RAM_READ, 13'h1555, 8'hFF);
      send_request(REQ_RAM_READ, 13'h0AAA, 8'hFF);
      send_request(REQ_UNUSED_LO, 13'h1FFF, 8'hFF);
      send_request(REQ_UNUSED_HI, 13'h0000, 8'h00);
      send_request(REQ_MODE, '0, 8'hFE);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         idle_pct = (phase >= PHASES - 2) ? 0 : IDLE_LEVELS[phase % 3];
         load_config(CART_CODES[phase],
                     (phase == 0) ? 4'd0 : (phase == 1) ? 4'd8 : (phase == 2) ? 4'd15 :
                     4'($urandom_range(0, 8)),
                     RAM_SIZES[phase % 8]);
         repeat (PHASE_ITEMS) begin
            send_random_request();
            if ($urandom_range(0, 99) < idle_pct)
               pause_requests($urandom_range(1, 16));
         end
      end

      drain();
      if (tracker.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
